// File: rtl/pgrw_pkg.sv
// Package for the pixel gap repair writer: configuration, item and decision
// types, status, material, register, channel and counter codes. No dependencies.
package pgrw_pkg;

    localparam int COUNT_BITS    = 24;
    localparam int OUT_CNT_BITS  = 24;
    localparam int NUM_CNT       = 6;
    localparam int CH_BITS       = 48;
    localparam int IN_DATA_BITS  = 56;
    localparam int OUT_DATA_BITS = 200;
    localparam int ADDR_BITS     = 5;

    localparam logic [7:0] BYTE_ALL = 8'hFF;

    localparam int CH_RED     = 0;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 2;
    localparam int CH_WHITE   = 3;
    localparam int CH_SUPPORT = 4;
    localparam int CH_VARNISH = 5;

    localparam logic [1:0] MAT_RGB     = 2'd0;
    localparam logic [1:0] MAT_WHITE   = 2'd1;
    localparam logic [1:0] MAT_VARNISH = 2'd2;
    localparam logic [1:0] MAT_NONE    = 2'd3;

    localparam logic [2:0] ST_UNTOUCHED = 3'd0;
    localparam logic [2:0] ST_FILL      = 3'd1;
    localparam logic [2:0] ST_SUPPORT   = 3'd2;
    localparam logic [2:0] ST_BG        = 3'd3;
    localparam logic [2:0] ST_OUTSIDE   = 3'd4;
    localparam logic [2:0] ST_WIDE      = 3'd5;
    localparam logic [2:0] ST_NO_MAT    = 3'd6;
    localparam logic [2:0] ST_CFG_ERR   = 3'd7;

    localparam logic [2:0] REG_FILL_MATERIAL   = 3'd0;
    localparam logic [2:0] REG_FILL_RED        = 3'd1;
    localparam logic [2:0] REG_FILL_GREEN      = 3'd2;
    localparam logic [2:0] REG_FILL_BLUE       = 3'd3;
    localparam logic [2:0] REG_FILL_LEVEL      = 3'd4;
    localparam logic [2:0] REG_SUPPORT_LEVEL   = 3'd5;
    localparam logic [2:0] REG_FILL_PLANNED    = 3'd6;
    localparam logic [2:0] REG_SUPPORT_PLANNED = 3'd7;

    localparam int CNT_REPAIRED = 0;
    localparam int CNT_FILL     = 1;
    localparam int CNT_SUPPORT  = 2;
    localparam int CNT_BG       = 3;
    localparam int CNT_OUTSIDE  = 4;
    localparam int CNT_WIDE     = 5;

    typedef struct packed {
        logic [1:0] fill_material;
        logic [7:0] fill_red;
        logic [7:0] fill_green;
        logic [7:0] fill_blue;
        logic [7:0] fill_level;
        logic [7:0] support_level;
        logic       fill_planned;
        logic       support_planned;
    } t_cfg;

    typedef struct packed {
        logic               frame_start;
        logic [CH_BITS-1:0] pixel_channels;
        logic               layer_empty;
        logic               want_model_fill;
        logic               want_support;
        logic               external_background;
        logic               in_expected_domain;
        logic               rejected_too_wide;
        logic               internal_void_repair;
    } t_item;

    typedef struct packed {
        logic [CH_BITS-1:0] new_channels;
        logic [2:0]         status;
        logic               set_model_fill;
        logic               set_support_fill;
        logic               set_internal_void;
        logic               clear_empty;
        logic [NUM_CNT-1:0] bump;
    } t_decision;

endpackage

// File: rtl/pixel_gap_repair_writer_unit.sv
// Pixel gap repair writer: input item register, repair decision, running counters,
// result register and APB-style configuration port. Uses pgrw_pkg and pgrw_decide.
// Path: an accepted pixel passes the input item register, then the result register.
// Throughput: one pixel per cycle; both stages advance whenever the result
//   register is empty or being taken.
// Reset (synchronous, active low): clears valid bits and counters, fill material none.
module pixel_gap_repair_writer_unit import pgrw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // tdata: pixel_channels[47:0], layer_empty, want_model_fill, want_support,
    //        external_background, in_expected_domain, rejected_too_wide,
    //        internal_void_repair, 1 pad bit
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // tuser: frame_start
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata: new_channels[47:0], status[2:0], set_model_fill, set_support_fill,
    //        set_internal_void, clear_empty, count_repaired, count_fill,
    //        count_support, count_blocked_background, count_blocked_outside,
    //        count_blocked_wide (24 bits each), 1 pad bit
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    t_cfg                                r_cfg;
    logic                                r_in_valid;
    t_item                               r_in;
    logic                                r_out_valid;
    t_decision                           r_out;
    logic [NUM_CNT-1:0][OUT_CNT_BITS-1:0] r_out_cnt;
    logic [NUM_CNT-1:0][COUNT_BITS-1:0]  r_cnt;
    logic [NUM_CNT-1:0][COUNT_BITS-1:0]  n_cnt;
    logic [NUM_CNT-1:0][OUT_CNT_BITS-1:0] n_out_cnt;
    t_decision                           dec;
    t_item                               in_item;
    logic                                adv;
    logic                                cfg_wr;
    logic [2:0]                          reg_idx;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [32:0]           SHOW_MAX = 33'((64'd1 << OUT_CNT_BITS) - 64'd1);

    function automatic logic [OUT_CNT_BITS-1:0] show(input logic [COUNT_BITS-1:0] c);
        logic [32:0] ext;
        ext = 33'(c);
        return (ext > SHOW_MAX) ? OUT_CNT_BITS'(SHOW_MAX) : ext[OUT_CNT_BITS-1:0];
    endfunction

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fill_material   <= MAT_NONE;
            r_cfg.fill_red        <= '0;
            r_cfg.fill_green      <= '0;
            r_cfg.fill_blue       <= '0;
            r_cfg.fill_level      <= '0;
            r_cfg.support_level   <= '0;
            r_cfg.fill_planned    <= 1'b0;
            r_cfg.support_planned <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FILL_MATERIAL:   r_cfg.fill_material   <= pwdata[1:0];
                REG_FILL_RED:        r_cfg.fill_red        <= pwdata[7:0];
                REG_FILL_GREEN:      r_cfg.fill_green      <= pwdata[7:0];
                REG_FILL_BLUE:       r_cfg.fill_blue       <= pwdata[7:0];
                REG_FILL_LEVEL:      r_cfg.fill_level      <= pwdata[7:0];
                REG_SUPPORT_LEVEL:   r_cfg.support_level   <= pwdata[7:0];
                REG_FILL_PLANNED:    r_cfg.fill_planned    <= pwdata[0];
                REG_SUPPORT_PLANNED: r_cfg.support_planned <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FILL_MATERIAL:   prdata = 32'(r_cfg.fill_material);
            REG_FILL_RED:        prdata = 32'(r_cfg.fill_red);
            REG_FILL_GREEN:      prdata = 32'(r_cfg.fill_green);
            REG_FILL_BLUE:       prdata = 32'(r_cfg.fill_blue);
            REG_FILL_LEVEL:      prdata = 32'(r_cfg.fill_level);
            REG_SUPPORT_LEVEL:   prdata = 32'(r_cfg.support_level);
            REG_FILL_PLANNED:    prdata = 32'(r_cfg.fill_planned);
            REG_SUPPORT_PLANNED: prdata = 32'(r_cfg.support_planned);
            default:             prdata = '0;
        endcase
    end

    // input item unpacking
    always_comb begin
        in_item.frame_start          = s_axis_tuser;
        in_item.pixel_channels       = s_axis_tdata[CH_BITS-1:0];
        in_item.layer_empty          = s_axis_tdata[CH_BITS];
        in_item.want_model_fill      = s_axis_tdata[CH_BITS+1];
        in_item.want_support         = s_axis_tdata[CH_BITS+2];
        in_item.external_background  = s_axis_tdata[CH_BITS+3];
        in_item.in_expected_domain   = s_axis_tdata[CH_BITS+4];
        in_item.rejected_too_wide    = s_axis_tdata[CH_BITS+5];
        in_item.internal_void_repair = s_axis_tdata[CH_BITS+6];
    end

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= in_item;
        end
    end

    pgrw_decide u_decide (
        .i_cfg  (r_cfg),
        .i_item (r_in),
        .o_dec  (dec)
    );

    // counters: clear at frame start, then saturating bump
    always_comb begin
        for (int i = 0; i < NUM_CNT; i++) begin
            n_cnt[i] = r_in.frame_start ? '0 : r_cnt[i];
            if (dec.bump[i] && n_cnt[i] != CNT_MAX) begin
                n_cnt[i] = n_cnt[i] + COUNT_BITS'(1);
            end
            n_out_cnt[i] = show(n_cnt[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out     <= dec;
            r_out_cnt <= n_out_cnt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0,
                            r_out_cnt[CNT_WIDE], r_out_cnt[CNT_OUTSIDE], r_out_cnt[CNT_BG],
                            r_out_cnt[CNT_SUPPORT], r_out_cnt[CNT_FILL],
                            r_out_cnt[CNT_REPAIRED],
                            r_out.clear_empty, r_out.set_internal_void,
                            r_out.set_support_fill, r_out.set_model_fill,
                            r_out.status, r_out.new_channels};

    // a held input item always means the result side is stalled
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    a_cfg_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && !r_in.frame_start && dec.status == ST_CFG_ERR)
        |=> $stable(r_cnt))
        else $error("counter moved on configuration error");

    a_repaired_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && !r_in.frame_start &&
         dec.status != ST_FILL && dec.status != ST_SUPPORT)
        |=> $stable(r_cnt[CNT_REPAIRED]))
        else $error("repaired counter moved without a repair");

    a_void_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.set_internal_void) |->
        (r_out.set_support_fill && r_out.status == ST_SUPPORT))
        else $error("internal void flag outside a support repair");

endmodule

// File: rtl/pgrw_decide.sv
// Per-pixel repair decision: blocking, material write, flags, counter bumps.
// Depends on pgrw_pkg.
module pgrw_decide import pgrw_pkg::*; (
    input  t_cfg      i_cfg,
    input  t_item     i_item,
    output t_decision o_dec
);

    logic               fill_dead;
    logic               sup_dead;
    logic [CH_BITS-1:0] px;

    always_comb begin
        fill_dead = i_cfg.fill_planned &&
            ((i_cfg.fill_material == MAT_RGB && i_cfg.fill_red == BYTE_ALL &&
              i_cfg.fill_green == BYTE_ALL && i_cfg.fill_blue == BYTE_ALL) ||
             ((i_cfg.fill_material == MAT_WHITE || i_cfg.fill_material == MAT_VARNISH) &&
              i_cfg.fill_level == BYTE_ALL) ||
             i_cfg.fill_material == MAT_NONE);
        sup_dead = i_cfg.support_planned && i_cfg.support_level == BYTE_ALL;

        px    = i_item.pixel_channels;
        o_dec = '0;

        if (fill_dead || sup_dead) begin
            o_dec.status = ST_CFG_ERR;
        end else if (!i_item.layer_empty ||
                     (!i_item.want_model_fill && !i_item.want_support)) begin
            o_dec.status = ST_UNTOUCHED;
        end else if (i_item.external_background) begin
            o_dec.status       = ST_BG;
            o_dec.bump[CNT_BG] = 1'b1;
        end else if (!i_item.in_expected_domain) begin
            o_dec.status            = ST_OUTSIDE;
            o_dec.bump[CNT_OUTSIDE] = 1'b1;
        end else if (i_item.rejected_too_wide) begin
            o_dec.status         = ST_WIDE;
            o_dec.bump[CNT_WIDE] = 1'b1;
        end else if (i_item.want_model_fill) begin
            if (i_cfg.fill_material == MAT_NONE) begin
                o_dec.status = ST_NO_MAT;
            end else begin
                case (i_cfg.fill_material)
                    MAT_RGB: begin
                        px[CH_RED*8 +: 8]   = i_cfg.fill_red;
                        px[CH_GREEN*8 +: 8] = i_cfg.fill_green;
                        px[CH_BLUE*8 +: 8]  = i_cfg.fill_blue;
                    end
                    MAT_WHITE: begin
                        px[CH_WHITE*8 +: 8] = i_cfg.fill_level;
                    end
                    default: begin
                        px[CH_VARNISH*8 +: 8] = i_cfg.fill_level;
                    end
                endcase
                o_dec.status             = ST_FILL;
                o_dec.set_model_fill     = 1'b1;
                o_dec.clear_empty        = 1'b1;
                o_dec.bump[CNT_FILL]     = 1'b1;
                o_dec.bump[CNT_REPAIRED] = 1'b1;
            end
        end else begin
            px[CH_SUPPORT*8 +: 8]    = i_cfg.support_level;
            o_dec.status             = ST_SUPPORT;
            o_dec.set_support_fill   = 1'b1;
            o_dec.set_internal_void  = i_item.internal_void_repair;
            o_dec.clear_empty        = 1'b1;
            o_dec.bump[CNT_SUPPORT]  = 1'b1;
            o_dec.bump[CNT_REPAIRED] = 1'b1;
        end

        o_dec.new_channels = px;
    end

endmodule
